// ===== sv/masked_pixel_to_rgba8_macros.svh =====
// Assertion macros shared by the masked_pixel_to_rgba8 RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef MASKED_PIXEL_TO_RGBA8_MACROS_SVH
`define MASKED_PIXEL_TO_RGBA8_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define MPR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("masked_pixel_to_rgba8: property violated");

// Condition must never be seen at a rising edge outside reset.
`define MPR_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("masked_pixel_to_rgba8: forbidden condition seen");

`else

`define MPR_ASSERT(label, clk, rst_n, prop)
`define MPR_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/mpr_pkg.sv =====
// Shared types, constants and helpers for the masked pixel unpacker.
// No dependencies; imported by every module of the block.
`default_nettype none

package mpr_pkg;

	localparam int MPR_WORD_W     = 32;
	localparam int MPR_QUOT_W     = 8;
	localparam int MPR_NUM_W      = MPR_WORD_W + MPR_QUOT_W;
	localparam int MPR_SHIFT_W    = $clog2(MPR_WORD_W);
	localparam int MPR_BPP_W      = 3;
	localparam int MPR_REG_IDX_W  = 3;
	localparam int MPR_CHANNELS   = 4;

	// Stages 1..3 unpack and form the numerator, then one stage per quotient bit.
	localparam int MPR_PREP_STAGES = 3;
	localparam int MPR_STAGES      = MPR_PREP_STAGES + MPR_QUOT_W;

	localparam logic [MPR_WORD_W-1:0] MPR_RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [MPR_WORD_W-1:0] MPR_GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [MPR_WORD_W-1:0] MPR_BLUE_MASK_RST  = 32'h0000_00FF;
	localparam logic [MPR_WORD_W-1:0] MPR_ALPHA_MASK_RST = 32'hFF00_0000;
	localparam logic [MPR_BPP_W-1:0]  MPR_BPP_RST        = 3'd4;

	localparam logic [MPR_QUOT_W-1:0] MPR_OPAQUE = 8'hFF;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	typedef enum logic [MPR_REG_IDX_W-1:0] {
		REG_RED_MASK        = 3'd0,
		REG_GREEN_MASK      = 3'd1,
		REG_BLUE_MASK       = 3'd2,
		REG_ALPHA_MASK      = 3'd3,
		REG_BYTES_PER_PIXEL = 3'd4
	} mpr_reg_t;

	// Per-stage register load enables; bit k loads stage k+1.
	typedef struct packed {
		logic [MPR_STAGES-1:0] load;
	} mpr_pipe_t;

	// Trailing zero count; zero for an all-zero word.
	function automatic logic [MPR_SHIFT_W-1:0] mpr_ctz(input logic [MPR_WORD_W-1:0] m);
		logic [MPR_SHIFT_W-1:0] n;
		n = '0;
		for (int i = MPR_WORD_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				n = MPR_SHIFT_W'(i);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mpr_pipe_ctrl.sv =====
// Valid bits and load enables of the pipeline, with bubble collapsing.
// Depends on mpr_pkg and masked_pixel_to_rgba8_macros.svh.
`default_nettype none
`include "masked_pixel_to_rgba8_macros.svh"

module mpr_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output mpr_pkg::mpr_pipe_t pipe
);
	import mpr_pkg::*;

	logic [MPR_STAGES-1:0] valid_q;
	logic [MPR_STAGES:0]   ready;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		ready[MPR_STAGES] = !out_stall;
		for (int k = MPR_STAGES - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	assign pipe.load = ready[MPR_STAGES-1:0];
	assign in_stall  = !ready[0];
	assign out_valid = valid_q[MPR_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~pipe.load) |
				({valid_q[MPR_STAGES-2:0], in_valid} & pipe.load);
		end
	end

	`MPR_ASSERT(a_stall_only_when_full, clk, arst_n, in_stall |-> (&valid_q))
	`MPR_NEVER(a_stall_with_free_output, clk, arst_n, in_stall && !out_stall)
	`MPR_ASSERT(a_fill_on_request, clk, arst_n, (in_valid && !in_stall && !(out_valid && !out_stall)) |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
	`MPR_ASSERT(a_drain_on_delivery, clk, arst_n, (!(in_valid && !in_stall) && out_valid && !out_stall) |=> ($countones(valid_q) + 1 == $past($countones(valid_q))))

endmodule

`default_nettype wire

// ===== sv/mpr_unpack.sv =====
// One channel, stages 1..3: mask and trailing zeros, align, rounded numerator.
// Depends on mpr_pkg.
`default_nettype none

module mpr_unpack (
	input  logic                             clk,
	input  mpr_pkg::mpr_pipe_t               pipe,
	input  logic [mpr_pkg::MPR_WORD_W-1:0]   pixel,
	input  logic [mpr_pkg::MPR_WORD_W-1:0]   mask,
	output logic [mpr_pkg::MPR_WORD_W-1:0]   rem_s3,
	output logic [mpr_pkg::MPR_QUOT_W-1:0]   lo_s3,
	output logic [mpr_pkg::MPR_WORD_W-1:0]   top_s3,
	output logic                             zero_s3
);
	import mpr_pkg::*;

	logic [MPR_WORD_W-1:0]  vm_s1;
	logic [MPR_WORD_W-1:0]  mask_s1;
	logic [MPR_SHIFT_W-1:0] tz_s1;
	logic                   zero_s1;
	logic [MPR_WORD_W-1:0]  raw_s2;
	logic [MPR_WORD_W-1:0]  top_s2;
	logic                   zero_s2;
	logic [MPR_NUM_W-1:0]   num;

	// raw*255 + top/2; below 256*top, so the quotient fits in eight bits
	assign num = {raw_s2, {MPR_QUOT_W{1'b0}}} - {{MPR_QUOT_W{1'b0}}, raw_s2}
		+ {{(MPR_QUOT_W + 1){1'b0}}, top_s2[MPR_WORD_W-1:1]};

	always_ff @(posedge clk) begin
		if (pipe.load[0]) begin
			vm_s1   <= pixel & mask;
			mask_s1 <= mask;
			tz_s1   <= mpr_ctz(mask);
			zero_s1 <= (mask == '0);
		end
		if (pipe.load[1]) begin
			raw_s2  <= vm_s1 >> tz_s1;
			top_s2  <= mask_s1 >> tz_s1;
			zero_s2 <= zero_s1;
		end
		if (pipe.load[2]) begin
			rem_s3  <= num[MPR_NUM_W-1:MPR_QUOT_W];
			lo_s3   <= num[MPR_QUOT_W-1:0];
			top_s3  <= top_s2;
			zero_s3 <= zero_s2;
		end
	end

endmodule

`default_nettype wire

// ===== sv/mpr_divider.sv =====
// One channel, restoring divider: one quotient bit per stage after stage 3.
// Depends on mpr_pkg.
`default_nettype none

module mpr_divider (
	input  logic                           clk,
	input  mpr_pkg::mpr_pipe_t             pipe,
	input  logic [mpr_pkg::MPR_WORD_W-1:0] rem_s3,
	input  logic [mpr_pkg::MPR_QUOT_W-1:0] lo_s3,
	input  logic [mpr_pkg::MPR_WORD_W-1:0] top_s3,
	input  logic                           zero_s3,
	output logic [mpr_pkg::MPR_QUOT_W-1:0] quot,
	output logic                           zero
);
	import mpr_pkg::*;

	localparam int First = MPR_PREP_STAGES + 1;
	localparam int Last  = MPR_STAGES;

	// Arrays are indexed by stage number.
	logic [MPR_WORD_W-1:0] rem_s  [First:Last];
	logic [MPR_QUOT_W-1:0] lo_s   [First:Last];
	logic [MPR_WORD_W-1:0] top_s  [First:Last];
	logic [MPR_QUOT_W-1:0] q_s    [First:Last];
	logic                  zero_s [First:Last];

	for (genvar s = First; s <= Last; s++) begin : g_step
		logic [MPR_WORD_W-1:0] rem_in;
		logic [MPR_QUOT_W-1:0] lo_in;
		logic [MPR_WORD_W-1:0] top_in;
		logic [MPR_QUOT_W-1:0] q_in;
		logic                  zero_in;
		logic [MPR_WORD_W:0]   trial;
		logic [MPR_WORD_W+1:0] diff;
		logic                  ge;

		if (s == First) begin : g_head
			assign rem_in  = rem_s3;
			assign lo_in   = lo_s3;
			assign top_in  = top_s3;
			assign q_in    = '0;
			assign zero_in = zero_s3;
		end else begin : g_link
			assign rem_in  = rem_s[s-1];
			assign lo_in   = lo_s[s-1];
			assign top_in  = top_s[s-1];
			assign q_in    = q_s[s-1];
			assign zero_in = zero_s[s-1];
		end

		// remainder stays below top, so the kept value fits the word
		assign trial = {rem_in, lo_in[MPR_QUOT_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, top_in};
		assign ge    = !diff[MPR_WORD_W+1];

		always_ff @(posedge clk) begin
			if (pipe.load[s-1]) begin
				rem_s[s]  <= ge ? diff[MPR_WORD_W-1:0] : trial[MPR_WORD_W-1:0];
				lo_s[s]   <= {lo_in[MPR_QUOT_W-2:0], 1'b0};
				top_s[s]  <= top_in;
				q_s[s]    <= {q_in[MPR_QUOT_W-2:0], ge};
				zero_s[s] <= zero_in;
			end
		end
	end

	assign quot = q_s[Last];
	assign zero = zero_s[Last];

endmodule

`default_nettype wire

// ===== sv/masked_pixel_to_rgba8.sv =====
// Bitmask pixel unpacker to 8-bit RGBA. Each request carries one pixel word,
// byte 0 in bits 7:0; bytes above bytes_per_pixel (clamped to 2..4) are
// cleared. Per channel the word is ANDed with the channel mask, shifted down
// by the mask's trailing zeros and rescaled as (raw*255 + max/2)/max, where
// max is the shifted mask; a zero color mask gives 0, a zero alpha mask 255.
// Throughput is one pixel per clock while out_stall is low. Three stages
// of unpacking (mask and trailing-zero count, alignment, rounded numerator)
// precede eight restoring divider stages per channel, one quotient bit
// each. Stages advance independently, so bubbles collapse and a request
// is taken while a result waits at the output if any stage is empty. Masks
// and pixel size must be written through the cfg port only while no request
// is in flight (not enforced); a write is used by the next request at once.
// Depends on mpr_pkg, mpr_pipe_ctrl, mpr_unpack and mpr_divider.
`default_nettype none

module masked_pixel_to_rgba8 (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [mpr_pkg::MPR_REG_IDX_W-1:0]   cfg_index,
	input  logic [mpr_pkg::MPR_WORD_W-1:0]      cfg_wdata,
	// pixel requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mpr_pkg::MPR_WORD_W-1:0]      pixel_word,
	// RGBA results
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mpr_pkg::MPR_QUOT_W-1:0]      red,
	output logic [mpr_pkg::MPR_QUOT_W-1:0]      green,
	output logic [mpr_pkg::MPR_QUOT_W-1:0]      blue,
	output logic [mpr_pkg::MPR_QUOT_W-1:0]      alpha
);
	import mpr_pkg::*;

	logic [MPR_WORD_W-1:0] red_mask_q;
	logic [MPR_WORD_W-1:0] green_mask_q;
	logic [MPR_WORD_W-1:0] blue_mask_q;
	logic [MPR_WORD_W-1:0] alpha_mask_q;
	logic [MPR_BPP_W-1:0]  bpp_q;

	logic [MPR_WORD_W-1:0] mask_ch [MPR_CHANNELS];
	logic [MPR_QUOT_W-1:0] quot_ch [MPR_CHANNELS];
	logic                  zero_ch [MPR_CHANNELS];
	logic [MPR_WORD_W-1:0] pixel_cut;
	mpr_pipe_t             pipe;

	// Config registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= MPR_RED_MASK_RST;
			green_mask_q <= MPR_GREEN_MASK_RST;
			blue_mask_q  <= MPR_BLUE_MASK_RST;
			alpha_mask_q <= MPR_ALPHA_MASK_RST;
			bpp_q        <= MPR_BPP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED_MASK:        red_mask_q   <= cfg_wdata;
				REG_GREEN_MASK:      green_mask_q <= cfg_wdata;
				REG_BLUE_MASK:       blue_mask_q  <= cfg_wdata;
				REG_ALPHA_MASK:      alpha_mask_q <= cfg_wdata;
				REG_BYTES_PER_PIXEL: bpp_q        <= cfg_wdata[MPR_BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// Clear bytes above the pixel size; sizes below 2 act as 2, above 4 as 4.
	always_comb begin
		case (bpp_q) inside
			[3'd0:3'd2]: pixel_cut = pixel_word & 32'h0000_FFFF;
			3'd3:        pixel_cut = pixel_word & 32'h00FF_FFFF;
			default:     pixel_cut = pixel_word;
		endcase
	end

	assign mask_ch[CH_RED]   = red_mask_q;
	assign mask_ch[CH_GREEN] = green_mask_q;
	assign mask_ch[CH_BLUE]  = blue_mask_q;
	assign mask_ch[CH_ALPHA] = alpha_mask_q;

	mpr_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pipe      (pipe)
	);

	// Four identical channel datapaths sharing the load enables.
	for (genvar c = 0; c < MPR_CHANNELS; c++) begin : g_ch
		logic [MPR_WORD_W-1:0] rem_s3;
		logic [MPR_QUOT_W-1:0] lo_s3;
		logic [MPR_WORD_W-1:0] top_s3;
		logic                  zero_s3;

		mpr_unpack u_unpack (
			.clk     (clk),
			.pipe    (pipe),
			.pixel   (pixel_cut),
			.mask    (mask_ch[c]),
			.rem_s3  (rem_s3),
			.lo_s3   (lo_s3),
			.top_s3  (top_s3),
			.zero_s3 (zero_s3)
		);

		mpr_divider u_div (
			.clk     (clk),
			.pipe    (pipe),
			.rem_s3  (rem_s3),
			.lo_s3   (lo_s3),
			.top_s3  (top_s3),
			.zero_s3 (zero_s3),
			.quot    (quot_ch[c]),
			.zero    (zero_ch[c])
		);
	end

	// Zero mask: color channels read 0, alpha reads fully opaque.
	assign red   = zero_ch[CH_RED]   ? '0 : quot_ch[CH_RED];
	assign green = zero_ch[CH_GREEN] ? '0 : quot_ch[CH_GREEN];
	assign blue  = zero_ch[CH_BLUE]  ? '0 : quot_ch[CH_BLUE];
	assign alpha = zero_ch[CH_ALPHA] ? MPR_OPAQUE : quot_ch[CH_ALPHA];

endmodule

`default_nettype wire
